[design/skdc_pkg.sv]
package skdc_pkg;

    // Channel and configuration widths
    localparam int SAMPLE_W   = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND     = 3'd6;

    typedef struct packed {
        logic signed [15:0] threshold_db;
        logic [12:0]        knee_width_db;
        logic [16:0]        inv_ratio;
        logic signed [13:0] makeup_gain_db;
        logic [15:0]        attack_coeff;
        logic [15:0]        release_coeff;
        logic [16:0]        blend;
    } cfg_t;

    // Register reset values
    localparam logic signed [15:0] RST_THRESHOLD = -16'sd5120;
    localparam logic [12:0]        RST_KNEE      = 13'd1536;
    localparam logic [16:0]        RST_INV_RATIO = 17'd16384;
    localparam logic signed [13:0] RST_MAKEUP    = 14'sd0;
    localparam logic [15:0]        RST_ATTACK    = 16'd64225;
    localparam logic [15:0]        RST_RELEASE   = 16'd65262;
    localparam logic [16:0]        RST_BLEND     = 17'd65536;

    // Arithmetic constants
    localparam logic [16:0]        ONE_Q16         = 17'd65536;
    localparam logic [18:0]        DB_PER_LOG2_Q16 = 19'd394566;
    localparam logic [21:0]        LOG2_PER_DB_Q24 = 22'd2786635;
    localparam logic signed [16:0] FLOOR_DB_Q8     = -17'sd40960;
    localparam logic signed [21:0] LOG2_FULL_SCALE = 22'sd1507328;
    localparam logic [40:0]        WET_LIMIT       = 41'h100_0000_0000;

    // Integer square root, used only to build the root table
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = v;
        root = '0;
        bitv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // 2^(2^-i) in Q1.30 for i = 1..16, each the truncated root of the last
    function automatic logic [15:0][31:0] exp2_roots();
        logic [15:0][31:0] c;
        logic [63:0]       t;
        t    = isqrt64(64'd1 << 61);
        c[0] = t[31:0];
        for (int i = 1; i < 16; i++) begin
            t    = isqrt64({2'b00, c[i-1], 30'b0});
            c[i] = t[31:0];
        end
        return c;
    endfunction

    localparam logic [15:0][31:0] EXP2_ROOT = exp2_roots();

endpackage

[design/skdc_cfg.sv]
module skdc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [skdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [skdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output skdc_pkg::cfg_t                      cfg
);

    skdc_pkg::cfg_t cfg_reg;
    skdc_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                skdc_pkg::REG_THRESHOLD: cfg_next.threshold_db   = cfg_data[15:0];
                skdc_pkg::REG_KNEE:      cfg_next.knee_width_db  = cfg_data[12:0];
                skdc_pkg::REG_INV_RATIO: cfg_next.inv_ratio      = cfg_data[16:0];
                skdc_pkg::REG_MAKEUP:    cfg_next.makeup_gain_db = cfg_data[13:0];
                skdc_pkg::REG_ATTACK:    cfg_next.attack_coeff   = cfg_data[15:0];
                skdc_pkg::REG_RELEASE:   cfg_next.release_coeff  = cfg_data[15:0];
                skdc_pkg::REG_BLEND:     cfg_next.blend          = cfg_data[16:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_db   <= skdc_pkg::RST_THRESHOLD;
            cfg_reg.knee_width_db  <= skdc_pkg::RST_KNEE;
            cfg_reg.inv_ratio      <= skdc_pkg::RST_INV_RATIO;
            cfg_reg.makeup_gain_db <= skdc_pkg::RST_MAKEUP;
            cfg_reg.attack_coeff   <= skdc_pkg::RST_ATTACK;
            cfg_reg.release_coeff  <= skdc_pkg::RST_RELEASE;
            cfg_reg.blend          <= skdc_pkg::RST_BLEND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/skdc_mul.sv]
module skdc_mul (
    input  logic               clk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod
);

    logic signed [65:0] prod_reg;

    // Register every product; the sequencer reads it in the following cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[design/skdc_seq.sv]
module skdc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  skdc_pkg::cfg_t     cfg,
    input  logic               start,
    input  logic [23:0]        sample_in,
    input  logic               start_of_block,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_take,
    output logic [23:0]        sample_out,
    output logic signed [32:0] mul_a,
    output logic signed [32:0] mul_b,
    input  logic signed [65:0] mul_prod
);

    typedef enum logic [31:0] {
        ST_IDLE    = 32'h0000_0001,
        ST_NORM    = 32'h0000_0002,
        ST_SQ_MUL  = 32'h0000_0004,
        ST_SQ_ACC  = 32'h0000_0008,
        ST_XG_MUL  = 32'h0000_0010,
        ST_XG_ACC  = 32'h0000_0020,
        ST_RED     = 32'h0000_0040,
        ST_KN_SQ   = 32'h0000_0080,
        ST_KN_K    = 32'h0000_0100,
        ST_KN_DIV0 = 32'h0000_0200,
        ST_KN_DIV  = 32'h0000_0400,
        ST_AB_MUL  = 32'h0000_0800,
        ST_AB_ACC  = 32'h0000_1000,
        ST_PK1     = 32'h0000_2000,
        ST_PK2     = 32'h0000_4000,
        ST_PK3     = 32'h0000_8000,
        ST_SM1     = 32'h0001_0000,
        ST_SM2     = 32'h0002_0000,
        ST_SM3     = 32'h0004_0000,
        ST_GAIN    = 32'h0008_0000,
        ST_L2_MUL  = 32'h0010_0000,
        ST_L2_ACC  = 32'h0020_0000,
        ST_EX_MUL  = 32'h0040_0000,
        ST_EX_ACC  = 32'h0080_0000,
        ST_WM_MUL  = 32'h0100_0000,
        ST_WM_ACC  = 32'h0200_0000,
        ST_MX1     = 32'h0400_0000,
        ST_MX2     = 32'h0800_0000,
        ST_MX3     = 32'h1000_0000,
        ST_MX4     = 32'h2000_0000,
        ST_OUT     = 32'h4000_0000,
        ST_DONE    = 32'h8000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               pass_reg, pass_next;
    logic               neg_reg, neg_next;
    logic [23:0]        mag_reg, mag_next;
    logic [23:0]        nrm_reg, nrm_next;
    logic [4:0]         e_reg, e_next;
    logic [31:0]        y_reg, y_next;
    logic [15:0]        frac_reg, frac_next;
    logic signed [16:0] xg_reg, xg_next;
    logic signed [17:0] d_reg, d_next;
    logic [14:0]        u_reg, u_next;
    logic [12:0]        rem_reg, rem_next;
    logic [20:0]        nl_reg, nl_next;
    logic [20:0]        q_reg, q_next;
    logic [23:0]        xl_reg, xl_next;
    logic [23:0]        peak_reg, peak_next;
    logic [23:0]        smooth_reg, smooth_next;
    logic [57:0]        acc_reg, acc_next;
    logic signed [26:0] g_reg, g_next;
    logic signed [10:0] ip_reg, ip_next;
    logic [15:0]        fp_reg, fp_next;
    logic [40:0]        wm_reg, wm_next;
    logic [23:0]        res_reg, res_next;

    // Derived configuration values
    logic [16:0]        slope;
    logic [16:0]        knee_k;
    logic [16:0]        blend_eff;
    logic [16:0]        dry_w;
    logic [16:0]        rel_w;
    logic [16:0]        att_w;

    // Level computer terms
    logic [23:0]        mag_c;
    logic signed [21:0] log_rel;
    logic signed [16:0] lvl;
    logic signed [17:0] d_c;
    logic [17:0]        ad_c;
    logic               knee_c;
    logic               above_c;
    logic signed [18:0] u_c;

    // Shared scratch terms
    logic [31:0]        sq_t;
    logic [13:0]        div_t;
    logic [13:0]        div_d;
    logic               div_ge;
    logic [41:0]        wsum;
    logic [25:0]        mix;
    logic [25:0]        pk;
    logic signed [26:0] l2_c;
    logic signed [11:0] shift_c;
    logic [63:0]        shifted;
    logic [41:0]        qp;
    logic [58:0]        qn_sum;
    logic [42:0]        qn;

    assign slope     = (cfg.inv_ratio > skdc_pkg::ONE_Q16) ? skdc_pkg::ONE_Q16 : cfg.inv_ratio;
    assign knee_k    = skdc_pkg::ONE_Q16 - slope;
    assign blend_eff = (cfg.blend > skdc_pkg::ONE_Q16) ? skdc_pkg::ONE_Q16 : cfg.blend;
    assign dry_w     = skdc_pkg::ONE_Q16 - blend_eff;
    assign rel_w     = skdc_pkg::ONE_Q16 - {1'b0, cfg.release_coeff};
    assign att_w     = skdc_pkg::ONE_Q16 - {1'b0, cfg.attack_coeff};

    assign mag_c   = sample_in[23] ? (~sample_in + 24'd1) : sample_in;
    assign log_rel = $signed({1'b0, e_reg, frac_reg}) - skdc_pkg::LOG2_FULL_SCALE;

    // Gain computer regions: first pass at the input level, second at 0 dB
    assign lvl     = pass_reg ? 17'sd0 : xg_reg;
    assign d_c     = {lvl[16], lvl} - {{2{cfg.threshold_db[15]}}, cfg.threshold_db};
    assign ad_c    = d_c[17] ? (~d_c + 18'd1) : d_c;
    assign knee_c  = (cfg.knee_width_db != 13'd0) && ({ad_c, 1'b0} <= {6'd0, cfg.knee_width_db});
    assign above_c = !d_c[17] && ({d_c, 1'b0} > {6'd0, cfg.knee_width_db});
    assign u_c     = {d_c, 1'b0} + $signed({6'd0, cfg.knee_width_db});

    assign sq_t    = mul_prod[61:30];
    assign div_t   = {rem_reg, nl_reg[20]};
    assign div_d   = div_t - {1'b0, cfg.knee_width_db};
    assign div_ge  = div_t >= {1'b0, cfg.knee_width_db};
    assign wsum    = {1'b0, acc_reg[40:0]} + {1'b0, mul_prod[40:0]};
    assign mix     = wsum[41:16];
    assign pk      = (mix > {2'b00, xl_reg}) ? mix : {2'b00, xl_reg};
    assign l2_c    = mul_prod[50:24];
    assign shift_c = 12'sd30 - {ip_reg[10], ip_reg};
    assign shifted = {9'd0, mul_prod[54:0]} >> shift_c[5:0];
    assign qp      = acc_reg[57:16];
    assign qn_sum  = {1'b0, acc_reg} + 59'd65535;
    assign qn      = qn_sum[58:16];

    // Route operands of the shared multiplier by step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_MUL:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, y_reg};
            end
            ST_XG_MUL:
            begin
                mul_a = {{11{log_rel[21]}}, log_rel};
                mul_b = {14'd0, skdc_pkg::DB_PER_LOG2_Q16};
            end
            ST_KN_SQ:
            begin
                mul_a = {18'd0, u_reg};
                mul_b = {18'd0, u_reg};
            end
            ST_KN_K:
            begin
                mul_a = {4'd0, mul_prod[28:0]};
                mul_b = {16'd0, knee_k};
            end
            ST_AB_MUL:
            begin
                mul_a = {{15{d_reg[17]}}, d_reg};
                mul_b = {16'd0, knee_k};
            end
            ST_PK1:
            begin
                mul_a = {17'd0, cfg.release_coeff};
                mul_b = {9'd0, peak_reg};
            end
            ST_PK2:
            begin
                mul_a = {16'd0, rel_w};
                mul_b = {9'd0, xl_reg};
            end
            ST_SM1:
            begin
                mul_a = {17'd0, cfg.attack_coeff};
                mul_b = {9'd0, smooth_reg};
            end
            ST_SM2:
            begin
                mul_a = {16'd0, att_w};
                mul_b = {9'd0, peak_reg};
            end
            ST_L2_MUL:
            begin
                mul_a = {{6{g_reg[26]}}, g_reg};
                mul_b = {11'd0, skdc_pkg::LOG2_PER_DB_Q24};
            end
            ST_EX_MUL:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, skdc_pkg::EXP2_ROOT[cnt_reg[3:0]]};
            end
            ST_WM_MUL:
            begin
                mul_a = {9'd0, mag_reg};
                mul_b = {1'b0, y_reg};
            end
            ST_MX1:
            begin
                mul_a = {16'd0, dry_w};
                mul_b = {9'd0, mag_reg};
            end
            ST_MX2:
            begin
                mul_a = {16'd0, blend_eff};
                mul_b = {9'd0, wm_reg[23:0]};
            end
            ST_MX3:
            begin
                mul_a = {16'd0, blend_eff};
                mul_b = {16'd0, wm_reg[40:24]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequence one item through the shared multiplier
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pass_next   = pass_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        nrm_next    = nrm_reg;
        e_next      = e_reg;
        y_next      = y_reg;
        frac_next   = frac_reg;
        xg_next     = xg_reg;
        d_next      = d_reg;
        u_next      = u_reg;
        rem_next    = rem_reg;
        nl_next     = nl_reg;
        q_next      = q_reg;
        xl_next     = xl_reg;
        peak_next   = peak_reg;
        smooth_next = smooth_reg;
        acc_next    = acc_reg;
        g_next      = g_reg;
        ip_next     = ip_reg;
        fp_next     = fp_reg;
        wm_next     = wm_reg;
        res_next    = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next  = sample_in[23];
                    mag_next  = mag_c;
                    pass_next = 1'b0;
                    if (start_of_block)
                    begin
                        peak_next   = '0;
                        smooth_next = '0;
                    end
                    if (mag_c == 24'd0)
                    begin
                        xg_next    = skdc_pkg::FLOOR_DB_Q8;
                        state_next = ST_RED;
                    end
                    else
                    begin
                        nrm_next   = mag_c;
                        e_next     = 5'd23;
                        state_next = ST_NORM;
                    end
                end
            end
            // Find the leading one, one bit a cycle
            ST_NORM:
            begin
                if (nrm_reg[23])
                begin
                    y_next     = {1'b0, nrm_reg, 7'd0};
                    frac_next  = '0;
                    cnt_next   = 5'd15;
                    state_next = ST_SQ_MUL;
                end
                else
                begin
                    nrm_next = {nrm_reg[22:0], 1'b0};
                    e_next   = e_reg - 5'd1;
                end
            end
            ST_SQ_MUL:
            begin
                state_next = ST_SQ_ACC;
            end
            // Square the mantissa and take one fraction bit
            ST_SQ_ACC:
            begin
                y_next    = sq_t[31] ? {1'b0, sq_t[31:1]} : sq_t;
                frac_next = {frac_reg[14:0], sq_t[31]};
                if (cnt_reg == 5'd0)
                begin
                    state_next = ST_XG_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 5'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_XG_MUL:
            begin
                state_next = ST_XG_ACC;
            end
            ST_XG_ACC:
            begin
                xg_next    = mul_prod[40:24];
                state_next = ST_RED;
            end
            // Pick the gain computer region
            ST_RED:
            begin
                d_next = d_c;
                u_next = u_c[14:0];
                if (knee_c)
                begin
                    state_next = ST_KN_SQ;
                end
                else if (above_c)
                begin
                    state_next = ST_AB_MUL;
                end
                else
                begin
                    xl_next    = '0;
                    state_next = pass_reg ? ST_GAIN : ST_PK1;
                end
            end
            ST_KN_SQ:
            begin
                state_next = ST_KN_K;
            end
            ST_KN_K:
            begin
                state_next = ST_KN_DIV0;
            end
            ST_KN_DIV0:
            begin
                rem_next   = mul_prod[44:32];
                nl_next    = mul_prod[31:11];
                q_next     = '0;
                cnt_next   = 5'd20;
                state_next = ST_KN_DIV;
            end
            // Restoring division by the knee width, one quotient bit a cycle
            ST_KN_DIV:
            begin
                rem_next = div_ge ? div_d[12:0] : div_t[12:0];
                nl_next  = {nl_reg[19:0], 1'b0};
                q_next   = {q_reg[19:0], div_ge};
                if (cnt_reg == 5'd0)
                begin
                    xl_next    = {3'd0, q_reg[19:0], div_ge};
                    state_next = pass_reg ? ST_GAIN : ST_PK1;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            ST_AB_MUL:
            begin
                state_next = ST_AB_ACC;
            end
            ST_AB_ACC:
            begin
                xl_next    = mul_prod[31:8];
                state_next = pass_reg ? ST_GAIN : ST_PK1;
            end
            // Release stage of the peak detector
            ST_PK1:
            begin
                state_next = ST_PK2;
            end
            ST_PK2:
            begin
                acc_next   = {17'd0, mul_prod[40:0]};
                state_next = ST_PK3;
            end
            ST_PK3:
            begin
                peak_next  = (pk[25:24] != 2'b00) ? 24'hFF_FFFF : pk[23:0];
                state_next = ST_SM1;
            end
            // Attack stage
            ST_SM1:
            begin
                state_next = ST_SM2;
            end
            ST_SM2:
            begin
                acc_next   = {17'd0, mul_prod[40:0]};
                state_next = ST_SM3;
            end
            ST_SM3:
            begin
                smooth_next = (mix[25:24] != 2'b00) ? 24'hFF_FFFF : mix[23:0];
                pass_next   = 1'b1;
                state_next  = ST_RED;
            end
            // Gain in dB: automatic makeup plus user makeup minus reduction
            ST_GAIN:
            begin
                g_next = $signed({3'd0, xl_reg})
                       + $signed({{5{cfg.makeup_gain_db[13]}}, cfg.makeup_gain_db, 8'd0})
                       - $signed({3'd0, smooth_reg});
                state_next = ST_L2_MUL;
            end
            ST_L2_MUL:
            begin
                state_next = ST_L2_ACC;
            end
            ST_L2_ACC:
            begin
                ip_next    = l2_c[26:16];
                fp_next    = l2_c[15:0];
                y_next     = 32'h4000_0000;
                cnt_next   = 5'd0;
                state_next = ST_EX_MUL;
            end
            ST_EX_MUL:
            begin
                state_next = ST_EX_ACC;
            end
            // Raise the fraction bit by bit through the root table
            ST_EX_ACC:
            begin
                if (fp_reg[15])
                begin
                    y_next = sq_t;
                end
                fp_next = {fp_reg[14:0], 1'b0};
                if (cnt_reg == 5'd15)
                begin
                    state_next = ST_WM_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = ST_EX_MUL;
                end
            end
            ST_WM_MUL:
            begin
                state_next = ST_WM_ACC;
            end
            // Scale by the integer part and limit the wet magnitude
            ST_WM_ACC:
            begin
                if (shift_c[11])
                begin
                    wm_next = (mul_prod[54:0] != 55'd0) ? skdc_pkg::WET_LIMIT : 41'd0;
                end
                else if (shift_c[10:6] != 5'd0)
                begin
                    wm_next = '0;
                end
                else if (shifted > {23'd0, skdc_pkg::WET_LIMIT})
                begin
                    wm_next = skdc_pkg::WET_LIMIT;
                end
                else
                begin
                    wm_next = shifted[40:0];
                end
                state_next = ST_MX1;
            end
            // Dry/wet mix on magnitudes, wet term in two partial products
            ST_MX1:
            begin
                state_next = ST_MX2;
            end
            ST_MX2:
            begin
                acc_next   = {17'd0, mul_prod[40:0]};
                state_next = ST_MX3;
            end
            ST_MX3:
            begin
                acc_next   = acc_reg + {17'd0, mul_prod[40:0]};
                state_next = ST_MX4;
            end
            ST_MX4:
            begin
                acc_next   = acc_reg + {mul_prod[33:0], 24'd0};
                state_next = ST_OUT;
            end
            // Restore the sign, round toward minus infinity and saturate
            ST_OUT:
            begin
                if (!neg_reg)
                begin
                    res_next = (qp > 42'd8388607) ? 24'h7F_FFFF : qp[23:0];
                end
                else
                begin
                    res_next = (qn > 43'd8388608) ? 24'h80_0000 : (~qn[23:0] + 24'd1);
                end
                state_next = ST_DONE;
            end
            // Hold the result until the output register takes it
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            peak_reg   <= '0;
            smooth_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            peak_reg   <= peak_next;
            smooth_reg <= smooth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        pass_reg <= pass_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        nrm_reg  <= nrm_next;
        e_reg    <= e_next;
        y_reg    <= y_next;
        frac_reg <= frac_next;
        xg_reg   <= xg_next;
        d_reg    <= d_next;
        u_reg    <= u_next;
        rem_reg  <= rem_next;
        nl_reg   <= nl_next;
        q_reg    <= q_next;
        xl_reg   <= xl_next;
        acc_reg  <= acc_next;
        g_reg    <= g_next;
        ip_reg   <= ip_next;
        fp_reg   <= fp_next;
        wm_reg   <= wm_next;
        res_reg  <= res_next;
    end

    assign idle       = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign sample_out = res_reg;

endmodule

[design/soft_knee_dynamic_compressor_unit.sv]
// Soft-knee feedforward compressor, one signed 24-bit audio sample per item.
// Input stream: s_tdata carries sample_in, s_tuser carries start_of_block,
// which clears both detector levels before that sample is processed.
// Output stream: m_tdata carries the compressed, blended, saturated sample.
// Settings are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while no item is in flight, which the block does not
// enforce. A write lands at the clock edge where cfg_we is high. A zero
// sample skips the log stage; every other sample is normalized and then
// squared. The work is paced by the single 33x33 multiplier that the steps
// share, plus the bit-serial knee divider (up to two knee passes per item).
// One item is in work at a time; s_tready is high only while the sequencer
// is idle, so a new item is taken only once the last has left the sequencer.
// A finished sample waits in the output register, so the next item may be
// taken while the receiver stalls; a second finished sample holds inside
// the sequencer until the output register frees.
// Reset clears the detector levels, restores the register defaults and
// empties the output register.
module soft_knee_dynamic_compressor_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // [23:0] sample_in
    input  logic                                s_tuser,   // [0] start_of_block
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [23:0]                         m_tdata,   // [23:0] sample_out
    input  logic                                cfg_we,
    input  logic [skdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [skdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    skdc_pkg::cfg_t     cfg;
    logic               seq_idle;
    logic               res_valid;
    logic               res_take;
    logic [23:0]        res_data;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_prod;
    logic               out_valid_reg, out_valid_next;
    logic [23:0]        out_data_reg;

    skdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    skdc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    skdc_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .start          (s_tvalid && s_tready),
        .sample_in      (s_tdata),
        .start_of_block (s_tuser),
        .idle           (seq_idle),
        .res_valid      (res_valid),
        .res_take       (res_take),
        .sample_out     (res_data),
        .mul_a          (mul_a),
        .mul_b          (mul_b),
        .mul_prod       (mul_prod)
    );

    assign s_tready = seq_idle;

    // Load the output register when it is empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[design/skdc_checker.sv]
module skdc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [23:0]                      m_tdata
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // The sequencer is busy right after it takes an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again while an item is in work");

    // A taken item does not produce a result too early
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind soft_knee_dynamic_compressor_unit skdc_checker u_skdc_checker (.*);

[dv/soft_knee_dynamic_compressor_unit_tb.sv]
`timescale 1ns / 1ps

module soft_knee_dynamic_compressor_unit_tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 400;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [23:0]                     s_tdata;   // [23:0] sample_in
    logic                            s_tuser;   // [0] start_of_block
    logic                            m_tvalid;
    logic                            m_tready;
    logic [23:0]                     m_tdata;   // [23:0] sample_out
    logic                            cfg_we;
    logic [skdc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [skdc_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor copy of registers and detector
    logic signed [15:0] thr_q;
    logic [12:0]        knee_q;
    logic [16:0]        slope_q;
    logic signed [13:0] makeup_q;
    logic [15:0]        atk_q;
    logic [15:0]        rel_q;
    logic [16:0]        mix_q;
    longint             peak_lvl;
    longint             smooth_lvl;

    logic [23:0] expected_samples[$];
    int          n_errors = 0;
    int          n_cycles = 0;
    bit          out_stall_en;
    bit          in_gap_en;
    bit          hold_off_req;
    bit          hold_done = 1'b0;

    soft_knee_dynamic_compressor_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // arithmetic shift right, rounding toward minus infinity
    function automatic longint shr_floor(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in Q16 by repeated squaring of the normalized mantissa
    function automatic longint log2_q16(input logic [23:0] m);
        int              e;
        longint unsigned y;
        longint          fr;
        e = 23;
        fr = 0;
        while (e > 0 && m[e] == 1'b0)
            e--;
        y = longint'(m) << (30 - e);
        for (int i = 15; i >= 0; i--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                fr |= 64'd1 << i;
            end
        end
        return longint'(e) * 65536 + fr;
    endfunction

    // 2^(f/65536) in Q1.30
    function automatic longint unsigned pow2_frac(input logic [15:0] f);
        longint unsigned y;
        longint unsigned c;
        y = 64'd1 << 30;
        c = 0;
        for (int i = 1; i <= 16; i++)
        begin
            c = (i == 1) ? int_sqrt(64'd1 << 61) : int_sqrt(c << 30);
            if (f[16-i])
                y = (y * c) >> 30;
        end
        return y;
    endfunction

    // gain reduction in Q8.16 for a level in Q8.8
    function automatic longint gain_reduction(input longint lvl);
        longint          d;
        longint          w;
        longint          ad;
        longint unsigned k;
        longint unsigned u;
        d = lvl - longint'(thr_q);
        w = longint'(knee_q);
        k = 65536 - ((slope_q > 17'd65536) ? 65536 : longint'(slope_q));
        ad = (d < 0) ? -d : d;
        if (w > 0 && 2 * ad <= w)
        begin
            u = longint'(2 * d + w);
            return longint'((k * u * u) / (64'd2048 * w));
        end
        if (2 * d > w)
            return longint'((longint'(d) * k) >> 8);
        return 0;
    endfunction

    function automatic longint clamp24u(input longint v);
        if (v < 0)
            return 0;
        if (v > 64'hFF_FFFF)
            return 64'hFF_FFFF;
        return v;
    endfunction

    // compute the compressed sample and advance the detector
    function automatic logic [23:0] compress_sample(input logic [23:0] smp, input bit sob);
        longint          x;
        longint          mag;
        longint          lvl;
        longint          red;
        longint          mx;
        longint          g;
        longint          l2;
        longint          ip;
        longint          fp;
        longint          sh;
        longint          wm;
        longint          wet;
        longint          o;
        longint          bl;
        longint unsigned p;
        x = longint'($signed(smp));
        mag = (x < 0) ? -x : x;
        bl = (mix_q > 17'd65536) ? 65536 : longint'(mix_q);
        if (sob)
        begin
            peak_lvl = 0;
            smooth_lvl = 0;
        end
        lvl = (mag != 0) ? shr_floor((log2_q16(mag[23:0]) - 23 * 65536) * 394566, 24)
                         : -40960;
        red = gain_reduction(lvl);
        mx = longint'((longint'(rel_q) * peak_lvl + (65536 - longint'(rel_q)) * red) >>> 16);
        peak_lvl = clamp24u((mx > red) ? mx : red);
        smooth_lvl = clamp24u((longint'(atk_q) * smooth_lvl
                               + (65536 - longint'(atk_q)) * peak_lvl) >>> 16);
        g = gain_reduction(0) + longint'(makeup_q) * 256 - smooth_lvl;
        l2 = shr_floor(g * 2786635, 24);
        ip = shr_floor(l2, 16);
        fp = l2 - ip * 65536;
        p = longint'(mag) * pow2_frac(fp[15:0]);
        sh = 30 - ip;
        if (sh < 0)
            wm = (p != 0) ? (64'd1 << 40) : 0;
        else if (sh > 63)
            wm = 0;
        else
            wm = longint'(p >> sh);
        if (wm > (64'd1 << 40))
            wm = 64'd1 << 40;
        wet = (x < 0) ? -wm : wm;
        o = shr_floor((65536 - bl) * x + bl * wet, 16);
        if (o > 8388607)
            o = 8388607;
        if (o < -8388608)
            o = -8388608;
        return o[23:0];
    endfunction

    function automatic void reset_registers();
        thr_q = skdc_pkg::RST_THRESHOLD;
        knee_q = skdc_pkg::RST_KNEE;
        slope_q = skdc_pkg::RST_INV_RATIO;
        makeup_q = skdc_pkg::RST_MAKEUP;
        atk_q = skdc_pkg::RST_ATTACK;
        rel_q = skdc_pkg::RST_RELEASE;
        mix_q = skdc_pkg::RST_BLEND;
        peak_lvl = 0;
        smooth_lvl = 0;
    endfunction

    // write one register and mirror it
    task automatic write_reg(input logic [skdc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [skdc_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            skdc_pkg::REG_THRESHOLD: thr_q = val[15:0];
            skdc_pkg::REG_KNEE:      knee_q = val[12:0];
            skdc_pkg::REG_INV_RATIO: slope_q = val[16:0];
            skdc_pkg::REG_MAKEUP:    makeup_q = val[13:0];
            skdc_pkg::REG_ATTACK:    atk_q = val[15:0];
            skdc_pkg::REG_RELEASE:   rel_q = val[15:0];
            skdc_pkg::REG_BLEND:     mix_q = val[16:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // wait for every pending result, then let the block settle
    task automatic wait_idle();
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // offer one item and hold it until accepted
    task automatic send_sample(input logic [23:0] smp, input bit sob);
        int gap;
        if (in_gap_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tuser <= sob;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_samples.insert(expected_samples.size(), compress_sample(smp, sob));
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [23:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 255)) ^ {24{$urandom_range(0, 1) == 1}};
            1: return {$urandom_range(0, 1) == 1 ? 1'b1 : 1'b0, 23'($urandom)};
            2: return 24'($urandom_range(0, 65535)) << $urandom_range(0, 8);
            default: return 24'($urandom);
        endcase
    endfunction

    // directed: field extremes at reset settings, then special-case settings
    task automatic test_directed();
        send_sample(24'h00_0000, 1'b1);
        send_sample(24'h7F_FFFF, 1'b0);
        send_sample(24'h80_0000, 1'b0);
        send_sample(24'h00_0001, 1'b0);
        send_sample(24'hFF_FFFF, 1'b0);
        send_sample(24'h55_AAAA, 1'b1);
        send_sample(24'hAA_5555, 1'b0);
        wait_idle();
        // zero knee, slope above one, blend above one
        write_reg(skdc_pkg::REG_KNEE, 17'd0);
        write_reg(skdc_pkg::REG_INV_RATIO, 17'h1_FFFF);
        write_reg(skdc_pkg::REG_BLEND, 17'h1_FFFF);
        send_sample(24'h40_0000, 1'b1);
        send_sample(24'hC0_0000, 1'b0);
        wait_idle();
        // huge gain saturates, bad index ignored
        write_reg(skdc_pkg::REG_INV_RATIO, 17'd1);
        write_reg(skdc_pkg::REG_THRESHOLD, 17'h1_A000);
        write_reg(skdc_pkg::REG_MAKEUP, 17'd6144);
        write_reg(3'd7, 17'h1_FFFF);
        send_sample(24'h7F_FFFF, 1'b1);
        send_sample(24'h00_0003, 1'b0);
        send_sample(24'hFF_FFF0, 1'b0);
        wait_idle();
        // detector overflow and extreme coefficients
        write_reg(skdc_pkg::REG_ATTACK, 17'd0);
        write_reg(skdc_pkg::REG_RELEASE, 17'd65535);
        write_reg(skdc_pkg::REG_KNEE, 17'd6144);
        write_reg(skdc_pkg::REG_THRESHOLD, 17'd0);
        write_reg(skdc_pkg::REG_MAKEUP, 17'h1_E800);
        write_reg(skdc_pkg::REG_BLEND, 17'd0);
        send_sample(24'h7F_FFFF, 1'b0);
        send_sample(24'h80_0001, 1'b0);
        wait_idle();
        write_reg(skdc_pkg::REG_BLEND, 17'd32768);
        send_sample(24'h12_3456, 1'b0);
        wait_idle();
    endtask

    // random settings followed by random blocks of samples
    task automatic test_random_phases(input int n_phases, input int per_phase);
        for (int ph = 0; ph < n_phases; ph++)
        begin
            write_reg(skdc_pkg::REG_THRESHOLD, 17'(-$urandom_range(0, 24576)));
            write_reg(skdc_pkg::REG_KNEE,
                      17'($urandom_range(0, 1) ? $urandom_range(0, 6144) : 0));
            write_reg(skdc_pkg::REG_INV_RATIO, 17'($urandom_range(1, 65536)));
            write_reg(skdc_pkg::REG_MAKEUP, 17'($signed($urandom_range(0, 12288)) - 6144));
            write_reg(skdc_pkg::REG_ATTACK, 17'($urandom_range(0, 65535)));
            write_reg(skdc_pkg::REG_RELEASE, 17'($urandom_range(0, 65535)));
            write_reg(skdc_pkg::REG_BLEND, 17'($urandom_range(0, 65536)));
            for (int i = 0; i < per_phase; i++)
                send_sample(random_sample(), ($urandom_range(0, 15) == 0) ? 1'b1 : 1'b0);
            wait_idle();
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        for (int i = 0; i < 6; i++)
            send_sample(random_sample(), 1'b0);
        wait_idle();
    endtask

    // receiver: random stalls and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (1500) @(negedge clk);
            end
            else if (out_stall_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: unexpected result %h", m_tdata);
                n_errors++;
            end
            else if (expected_samples[0] !== m_tdata)
            begin
                $error("sample_out: expected %h actual %h", expected_samples[0], m_tdata);
                n_errors++;
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        out_stall_en = 1'b1;
        in_gap_en = 1'b1;
        hold_off_req = 1'b0;
        reset_registers();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random_phases(12, 50);
        out_stall_en = 1'b0;
        in_gap_en = 1'b0;
        test_random_phases(2, 50);
        if (n_errors == 0 && expected_samples.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
